// File: rtl/rpfa_pkg.sv
package rpfa_pkg;

    // Geometry of the managed region. NUM_PAGES must be a power of two.
    localparam int NUM_PAGES  = 32768;
    localparam int PAGE_BYTES = 4096;
    localparam int COUNT_BITS = 8;

    localparam int ADDR_W     = 32;
    localparam int IDX_BITS   = $clog2(NUM_PAGES);
    localparam int OFF_BITS   = $clog2(PAGE_BYTES);
    localparam int DEPTH_BITS = IDX_BITS + 1;
    localparam int TAKEN_BITS = IDX_BITS + 1;

    // Wide enough for rounded-up addresses and for ram_base plus the full page span.
    localparam int EXT_W = ((ADDR_W > IDX_BITS + OFF_BITS) ? ADDR_W : IDX_BITS + OFF_BITS) + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_ADDREF = 2'd2,
        OP_READ   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OOM      = 3'd1,
        ST_BADADDR  = 3'd2,
        ST_NOTALLOC = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CFG_RAM_BASE   = 2'd0,
        CFG_FIRST_FREE = 2'd1,
        CFG_RAM_TOP    = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_POP,
        S_FRESH,
        S_FRESH_IDX,
        S_READ
    } t_state;

    typedef struct packed {
        logic                ok;
        logic [IDX_BITS-1:0] idx;
    } t_addr_chk;

    typedef struct packed {
        logic [EXT_W-1:0] lo;
        logic [EXT_W-1:0] hi;
    } t_geom;

endpackage

// File: rtl/rpfa_ram.sv
module rpfa_ram #(
    parameter int ADDR_BITS = 1,
    parameter int DATA_BITS = 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/rpfa_addr_unit.sv
module rpfa_addr_unit
    import rpfa_pkg::*;
(
    input  logic [ADDR_W-1:0] i_phys_addr,
    input  logic [ADDR_W-1:0] i_ram_base,
    input  logic [ADDR_W-1:0] i_first_free,
    input  logic [ADDR_W-1:0] i_ram_top,
    output t_addr_chk         o_chk,
    output t_geom             o_geom
);

    localparam logic [EXT_W-1:0] PAGE_MASK = EXT_W'(PAGE_BYTES - 1);
    localparam logic [EXT_W-1:0] SPAN_MAX  = EXT_W'(NUM_PAGES) << OFF_BITS;

    logic [EXT_W-1:0] diff;
    logic             aligned;
    logic             in_range;
    logic             off_ok;
    logic [EXT_W-1:0] ffa_up;
    logic [EXT_W-1:0] base_up;
    logic [EXT_W-1:0] lim;
    logic [EXT_W-1:0] hi_raw;

    // Address check for free, add reference and read.
    assign aligned  = (i_phys_addr[OFF_BITS-1:0] == '0);
    assign in_range = (i_phys_addr >= i_first_free) && (i_phys_addr < i_ram_top) &&
                      (i_phys_addr >= i_ram_base);
    assign diff     = EXT_W'(i_phys_addr) - EXT_W'(i_ram_base);
    assign off_ok   = (diff[EXT_W-1:OFF_BITS+IDX_BITS] == '0);

    assign o_chk.ok  = aligned && in_range && off_ok;
    assign o_chk.idx = diff[OFF_BITS +: IDX_BITS];

    // Bounds of the never-used region, both on page boundaries.
    assign ffa_up  = (EXT_W'(i_first_free) + PAGE_MASK) & ~PAGE_MASK;
    assign base_up = (EXT_W'(i_ram_base) + PAGE_MASK) & ~PAGE_MASK;
    assign lim     = EXT_W'(i_ram_base) + SPAN_MAX;
    assign hi_raw  = (lim < EXT_W'(i_ram_top)) ? lim : EXT_W'(i_ram_top);

    assign o_geom.lo = (base_up > ffa_up) ? base_up : ffa_up;
    assign o_geom.hi = hi_raw & ~PAGE_MASK;

endmodule

// File: rtl/refcounted_page_frame_allocator.sv
// Page frame allocator with a reference count per page. A request is taken at a rising
// edge with start high and busy low; its single result is presented for exactly one cycle
// with o_done high, and there is no way to hold it off, so the receiver must capture the
// status, page address and count in that cycle. busy falls in the cycle that carries the
// result, so a new request may follow at once. The count memory has a registered read:
// free, add reference and read count check the address in the decode state, then modify
// and write back the count in the read state, before the next request is decoded; an
// allocate from the freed-page stack reads the stack in a pop state first, and an allocate
// of a fresh page takes two address steps (fresh and fresh index) first. A bad address is
// answered from the decode state and an exhausted fresh region from the fresh state. After
// reset the block is busy while it writes zero to every count; configuration writes are
// taken during that sweep.
module refcounted_page_frame_allocator
    import rpfa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_opcode,
    input  logic [ADDR_W-1:0]     i_phys_addr,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [ADDR_W-1:0]     i_cfg_data,
    output logic                  o_done,
    output logic [2:0]            o_status,
    output logic [ADDR_W-1:0]     o_page_addr,
    output logic [COUNT_BITS-1:0] o_ref_count
);

    // Configuration registers.
    logic [ADDR_W-1:0] r_ram_base;
    logic [ADDR_W-1:0] r_first_free;
    logic [ADDR_W-1:0] r_ram_top;

    // Sequencer and allocator state.
    t_state                r_state, n_state;
    logic [DEPTH_BITS-1:0] r_depth, n_depth;
    logic [TAKEN_BITS-1:0] r_taken, n_taken;
    logic [IDX_BITS-1:0]   r_clr_addr, n_clr_addr;
    logic                  r_done, n_done;

    // Per-transaction working registers.
    t_opcode             r_op, n_op;
    logic [ADDR_W-1:0]   r_pa, n_pa;
    logic [IDX_BITS-1:0] r_idx, n_idx;
    logic [EXT_W-1:0]    r_lo, n_lo;
    logic [EXT_W-1:0]    r_hi, n_hi;
    logic [EXT_W-1:0]    r_need, n_need;
    logic [EXT_W-1:0]    r_a, n_a;
    logic [ADDR_W-1:0]   r_page_addr, n_page_addr;

    // Result registers.
    t_status             r_status, n_status;
    logic [ADDR_W-1:0]   r_out_addr, n_out_addr;
    logic [COUNT_BITS-1:0] r_ref_count, n_ref_count;

    // Memory ports.
    logic                  cnt_we;
    logic [IDX_BITS-1:0]   cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [IDX_BITS-1:0]   cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_rdata;
    logic                  stk_we;
    logic [IDX_BITS-1:0]   stk_waddr;
    logic [IDX_BITS-1:0]   stk_wdata;
    logic [IDX_BITS-1:0]   stk_raddr;
    logic [IDX_BITS-1:0]   stk_rdata;

    t_addr_chk             chk;
    t_geom                 geom;
    logic [DEPTH_BITS-1:0] depth_dec;
    logic                  fresh_ok;
    logic [EXT_W-1:0]      a_off;

    rpfa_addr_unit u_addr (
        .i_phys_addr  (r_pa),
        .i_ram_base   (r_ram_base),
        .i_first_free (r_first_free),
        .i_ram_top    (r_ram_top),
        .o_chk        (chk),
        .o_geom       (geom)
    );

    // Reference counts, one per page; cleared by the sweep that follows reset.
    rpfa_ram #(
        .ADDR_BITS (IDX_BITS),
        .DATA_BITS (COUNT_BITS)
    ) u_count_mem (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    // Stack of freed page indices; only entries below the depth are ever read.
    rpfa_ram #(
        .ADDR_BITS (IDX_BITS),
        .DATA_BITS (IDX_BITS)
    ) u_stack_mem (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign depth_dec = r_depth - 1'b1;

    // The fresh region must be non-empty and still hold the next page below its top.
    assign fresh_ok = (r_hi > r_lo) && (r_need <= (r_hi - r_lo));

    // Offset of the chosen fresh page from the base; never negative, as the region
    // starts at or above the rounded-up base.
    assign a_off = r_a - EXT_W'(r_ram_base);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_op == OP_ALLOC) begin
                    n_state = (r_depth != '0) ? S_POP : S_FRESH;
                end else begin
                    n_state = chk.ok ? S_READ : S_IDLE;
                end
            end
            S_POP:       n_state = S_READ;
            S_FRESH:     n_state = fresh_ok ? S_FRESH_IDX : S_IDLE;
            S_FRESH_IDX: n_state = S_READ;
            S_READ:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Datapath, memory controls and results.
    always_comb begin
        n_depth     = r_depth;
        n_taken     = r_taken;
        n_clr_addr  = r_clr_addr;
        n_done      = 1'b0;
        n_op        = r_op;
        n_pa        = r_pa;
        n_idx       = r_idx;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_need      = r_need;
        n_a         = r_a;
        n_page_addr = r_page_addr;
        n_status    = r_status;
        n_out_addr  = r_out_addr;
        n_ref_count = r_ref_count;

        cnt_we    = 1'b0;
        cnt_waddr = r_idx;
        cnt_wdata = '0;
        cnt_raddr = r_idx;
        stk_we    = 1'b0;
        stk_waddr = r_depth[IDX_BITS-1:0];
        stk_wdata = r_idx;
        stk_raddr = depth_dec[IDX_BITS-1:0];

        unique case (r_state)
            S_CLEAR: begin
                cnt_we     = 1'b1;
                cnt_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
            end
            S_IDLE: begin
                if (start) begin
                    n_op = t_opcode'(i_opcode);
                    n_pa = i_phys_addr;
                end
            end
            S_DECODE: begin
                if (r_op == OP_ALLOC) begin
                    if (r_depth != '0) begin
                        // The stack read address is the new top, already on the port.
                        n_depth = depth_dec;
                    end else begin
                        n_lo   = geom.lo;
                        n_hi   = geom.hi;
                        n_need = (EXT_W'(r_taken) + 1'b1) << OFF_BITS;
                    end
                end else if (chk.ok) begin
                    n_idx     = chk.idx;
                    cnt_raddr = chk.idx;
                end else begin
                    n_done      = 1'b1;
                    n_status    = ST_BADADDR;
                    n_out_addr  = '0;
                    n_ref_count = '0;
                end
            end
            S_POP: begin
                n_idx       = stk_rdata;
                cnt_raddr   = stk_rdata;
                n_page_addr = r_ram_base + ADDR_W'({stk_rdata, {OFF_BITS{1'b0}}});
            end
            S_FRESH: begin
                if (fresh_ok) begin
                    n_a     = r_hi - r_need;
                    n_taken = r_taken + 1'b1;
                end else begin
                    n_done      = 1'b1;
                    n_status    = ST_OOM;
                    n_out_addr  = '0;
                    n_ref_count = '0;
                end
            end
            S_FRESH_IDX: begin
                n_idx       = a_off[OFF_BITS +: IDX_BITS];
                cnt_raddr   = a_off[OFF_BITS +: IDX_BITS];
                n_page_addr = r_a[ADDR_W-1:0];
            end
            S_READ: begin
                n_done     = 1'b1;
                n_out_addr = '0;
                case (r_op)
                    OP_ALLOC: begin
                        if (cnt_rdata != '0) begin
                            // A stale page: the slot is consumed but nothing is handed out.
                            n_status    = ST_OOM;
                            n_ref_count = '0;
                        end else begin
                            cnt_we      = 1'b1;
                            cnt_wdata   = COUNT_BITS'(1);
                            n_status    = ST_OK;
                            n_out_addr  = r_page_addr;
                            n_ref_count = COUNT_BITS'(1);
                        end
                    end
                    OP_READ: begin
                        n_status    = ST_OK;
                        n_ref_count = cnt_rdata;
                    end
                    OP_FREE: begin
                        if (cnt_rdata == '0) begin
                            n_status    = ST_NOTALLOC;
                            n_ref_count = '0;
                        end else begin
                            cnt_we      = 1'b1;
                            cnt_wdata   = cnt_rdata - 1'b1;
                            n_status    = ST_OK;
                            n_ref_count = cnt_rdata - 1'b1;
                            // Last reference gone: push the page unless the stack is full.
                            if (cnt_rdata == COUNT_BITS'(1) && !r_depth[IDX_BITS]) begin
                                stk_we  = 1'b1;
                                n_depth = r_depth + 1'b1;
                            end
                        end
                    end
                    OP_ADDREF: begin
                        if (cnt_rdata == '0) begin
                            n_status    = ST_NOTALLOC;
                            n_ref_count = '0;
                        end else if (cnt_rdata == COUNT_MAX) begin
                            n_status    = ST_OVERFLOW;
                            n_ref_count = cnt_rdata;
                        end else begin
                            cnt_we      = 1'b1;
                            cnt_wdata   = cnt_rdata + 1'b1;
                            n_status    = ST_OK;
                            n_ref_count = cnt_rdata + 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_depth      <= '0;
            r_taken      <= '0;
            r_clr_addr   <= '0;
            r_done       <= 1'b0;
            r_ram_base   <= 32'h8000_0000;
            r_first_free <= 32'h8010_0000;
            r_ram_top    <= 32'h8800_0000;
        end else begin
            r_state    <= n_state;
            r_depth    <= n_depth;
            r_taken    <= n_taken;
            r_clr_addr <= n_clr_addr;
            r_done     <= n_done;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_RAM_BASE:   r_ram_base   <= i_cfg_data;
                    CFG_FIRST_FREE: r_first_free <= i_cfg_data;
                    CFG_RAM_TOP:    r_ram_top    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_pa        <= n_pa;
        r_idx       <= n_idx;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_need      <= n_need;
        r_a         <= n_a;
        r_page_addr <= n_page_addr;
        r_status    <= n_status;
        r_out_addr  <= n_out_addr;
        r_ref_count <= n_ref_count;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_page_addr = r_out_addr;
    assign o_ref_count = r_ref_count;

    // A result only ever follows the states that finish a transaction.
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == S_READ || $past(r_state) == S_DECODE ||
                    $past(r_state) == S_FRESH))
        else $error("result strobe without a finishing state");

    // The freed-page stack never grows beyond the number of pages.
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_BITS'(NUM_PAGES))
        else $error("freed-page stack depth out of range");

    // A handed-out page always comes back with a single reference.
    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_page_addr != '0) |-> (o_status == ST_OK && o_ref_count == COUNT_BITS'(1)))
        else $error("allocated page without a count of one");

    // The count memory is never written while the block is waiting for a request.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !cnt_we)
        else $error("count memory written while idle");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

// Testbench for the reference-counted page frame allocator.
//
// Requests are queued by the stimulus thread and handed to the block by a driver that works on
// the falling clock edge. A monitor on the rising edge spots each accepted transaction, runs it
// through a predictor that keeps its own copy of the count store, the freed-page stack and the
// fresh-page counter, and files the expected result. Every result the block strobes out is
// compared against the oldest expected one. The block cannot be back-pressured, so only the
// request side ever idles.
//
// The run moves through several register settings. It starts on the reset values, then uses a
// small region where the fresh pages run out. Next it sets a region whose next fresh slot lands
// on a page that is still in use, then one where every address is rejected. It finishes back
// on the reset values, including a run of add-reference requests that saturates one count.
module tb_top;
    import rpfa_pkg::*;

    localparam logic [ADDR_W-1:0] DEFAULT_RAM_BASE   = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] DEFAULT_FIRST_FREE = 32'h8010_0000;
    localparam logic [ADDR_W-1:0] DEFAULT_RAM_TOP    = 32'h8800_0000;

    // Cycles without any accepted transaction, result or register write before giving up.
    // The count-clearing sweep after reset is itself a stretch without any of these.
    localparam int STALL_LIMIT = 150000;

    typedef struct packed {
        t_opcode           op;
        logic [ADDR_W-1:0] addr;
    } t_page_request;

    typedef struct packed {
        t_status               status;
        logic [ADDR_W-1:0]     page;
        logic [COUNT_BITS-1:0] count;
    } t_page_result;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic [1:0]            i_opcode    = OP_READ;
    logic [ADDR_W-1:0]     i_phys_addr = '0;
    logic                  i_cfg_we    = 1'b0;
    logic [1:0]            i_cfg_index = CFG_RAM_BASE;
    logic [ADDR_W-1:0]     i_cfg_data  = '0;
    logic                  busy;
    logic                  o_done;
    logic [2:0]            o_status;
    logic [ADDR_W-1:0]     o_page_addr;
    logic [COUNT_BITS-1:0] o_ref_count;

    refcounted_page_frame_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_opcode    (i_opcode),
        .i_phys_addr (i_phys_addr),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_page_addr (o_page_addr),
        .o_ref_count (o_ref_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Our own picture of the allocator: registers, per-page counts, freed-page stack and the
    // number of fresh pages handed out so far.
    logic [ADDR_W-1:0]     cfg_base  = DEFAULT_RAM_BASE;
    logic [ADDR_W-1:0]     cfg_first = DEFAULT_FIRST_FREE;
    logic [ADDR_W-1:0]     cfg_top   = DEFAULT_RAM_TOP;
    logic [COUNT_BITS-1:0] page_counts [NUM_PAGES];
    logic [IDX_BITS-1:0]   freed_pages [NUM_PAGES];
    int unsigned           freed_depth = 0;
    int unsigned           fresh_taken = 0;
    // Indices of pages whose count is not zero; the stimulus picks most of its addresses here.
    int unsigned           live_pages [$];

    t_page_request requests_pending [$];
    t_page_result  results_due [$];
    t_page_request next_req;
    bit            req_taken    = 1'b0;
    bit            gaps_on      = 1'b1;
    int            gap_left     = 0;
    int            mismatches   = 0;
    int            quiet_cycles = 0;
    bit            stalled      = 1'b0;

    initial begin
        foreach (page_counts[i]) page_counts[i] = '0;
    end

    function automatic longint unsigned page_round_up(longint unsigned v);
        return ((v + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
    endfunction

    // Applies one request to the model state and returns the result the block should give.
    function automatic t_page_result next_page_result(t_opcode op, logic [ADDR_W-1:0] pa);
        t_page_result      res;
        int unsigned       idx;
        int                k;
        longint unsigned   lo, hi, cap, step, a;
        logic [ADDR_W-1:0] page_pa;
        res = '{status: ST_OK, page: '0, count: '0};
        if (op == OP_ALLOC) begin
            res.status = ST_OOM;
            if (freed_depth != 0) begin
                freed_depth--;
                idx = freed_pages[freed_depth];
                page_pa = cfg_base + idx * PAGE_BYTES;
            end else begin
                // Fresh region: rounded-up start, end clipped to the managed span and rounded
                // down; pages are handed out from the top.
                lo = page_round_up(cfg_first);
                if (page_round_up(cfg_base) > lo) lo = page_round_up(cfg_base);
                cap = cfg_base;
                cap = cap + NUM_PAGES * PAGE_BYTES;
                hi = cfg_top;
                if (cap < hi) hi = cap;
                hi = (hi / PAGE_BYTES) * PAGE_BYTES;
                step = fresh_taken;
                step = (step + 1) * PAGE_BYTES;
                if (hi <= lo || step > hi - lo) return res;
                a = hi - step;
                fresh_taken++;
                cap = cfg_base;
                idx = ((a - cap) / PAGE_BYTES) % NUM_PAGES;
                // The fresh page is reported at its own address, which sits on a page
                // boundary even when the base does not.
                page_pa = ADDR_W'(a);
            end
            // A page that is still in use is consumed but not handed out.
            if (page_counts[idx] != 0) return res;
            page_counts[idx] = 1;
            live_pages.push_back(idx);
            res = '{status: ST_OK, page: page_pa, count: 1};
            return res;
        end
        if (pa % PAGE_BYTES != 0 || pa < cfg_first || pa >= cfg_top || pa < cfg_base
                || (pa - cfg_base) / PAGE_BYTES >= NUM_PAGES) begin
            res.status = ST_BADADDR;
            return res;
        end
        idx = (pa - cfg_base) / PAGE_BYTES;
        if (op == OP_READ) begin
            res.count = page_counts[idx];
        end else if (page_counts[idx] == 0) begin
            res.status = ST_NOTALLOC;
        end else if (op == OP_FREE) begin
            page_counts[idx]--;
            res.count = page_counts[idx];
            if (res.count == 0) begin
                for (k = 0; k < live_pages.size(); k++) begin
                    if (live_pages[k] == idx) begin
                        live_pages.delete(k);
                        break;
                    end
                end
                // A push onto a full stack is lost, and the page with it.
                if (freed_depth < NUM_PAGES) begin
                    freed_pages[freed_depth] = idx;
                    freed_depth++;
                end
            end
        end else if (page_counts[idx] == COUNT_MAX) begin
            res.status = ST_OVERFLOW;
            res.count  = page_counts[idx];
        end else begin
            page_counts[idx]++;
            res.count = page_counts[idx];
        end
        return res;
    endfunction

    // Driver: a request stays on the ports until the block takes it. After each transaction
    // the request side may pause for a short random burst.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || req_taken) begin
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end else if (requests_pending.size() != 0) begin
                next_req = requests_pending.pop_front();
                i_opcode    <= next_req.op;
                i_phys_addr <= next_req.addr;
                start       <= 1'b1;
                if (gaps_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 6);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks the result strobed in this cycle before filing the expectation of a
    // request taken at the same edge, since busy drops in the very cycle that carries a result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken = 1'b0;
        end else begin
            if (o_done) begin
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d page %h count %0d",
                                 o_status, o_page_addr, o_ref_count);
                end else begin
                    t_page_result want;
                    want = results_due.pop_front();
                    if (o_status !== want.status || o_page_addr !== want.page
                            || o_ref_count !== want.count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected status %0d page %h count %0d, %s",
                                     want.status, want.page, want.count,
                                     $sformatf("got status %0d page %h count %0d",
                                               o_status, o_page_addr, o_ref_count));
                    end
                end
            end
            req_taken = start && !busy;
            if (req_taken)
                results_due.push_back(next_page_result(t_opcode'(i_opcode), i_phys_addr));
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_RAM_BASE:   cfg_base  = i_cfg_data;
                    CFG_FIRST_FREE: cfg_first = i_cfg_data;
                    CFG_RAM_TOP:    cfg_top   = i_cfg_data;
                    default: ;
                endcase
            end
            if (req_taken || o_done || i_cfg_we) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) stalled = 1'b1;
        end
    end

    // Keeps the pending queue short so that requests are built from an up-to-date view of
    // which pages are live.
    task automatic send(t_opcode op, logic [ADDR_W-1:0] pa);
        while (requests_pending.size() >= 2) begin
            @(posedge i_clk);
            #1;
        end
        requests_pending.push_back('{op: op, addr: pa});
    endtask

    task automatic wait_idle();
        while (requests_pending.size() != 0 || start || results_due.size() != 0) begin
            @(posedge i_clk);
            #1;
        end
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [ADDR_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly well-formed traffic on live pages, with the rest made up of rejected addresses,
    // pages that were never allocated and misaligned addresses.
    task automatic send_random(int unsigned alloc_pct);
        int unsigned       roll, idx;
        t_opcode           op;
        logic [ADDR_W-1:0] pa;
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct) begin
            op = OP_ALLOC;
            pa = $urandom;
        end else if (roll < 85 && live_pages.size() != 0) begin
            idx = live_pages[$urandom_range(0, live_pages.size() - 1)];
            pa  = cfg_base + idx * PAGE_BYTES;
            case ($urandom_range(0, 3))
                0, 1:    op = OP_FREE;
                2:       op = OP_ADDREF;
                default: op = OP_READ;
            endcase
        end else begin
            op  = t_opcode'($urandom_range(0, 3));
            idx = $urandom_range(0, NUM_PAGES - 1);
            case ($urandom_range(0, 3))
                0:       pa = $urandom;
                1:       pa = cfg_base + idx * PAGE_BYTES + $urandom_range(1, PAGE_BYTES - 1);
                default: pa = cfg_base + idx * PAGE_BYTES;
            endcase
        end
        send(op, pa);
    endtask

    task automatic random_stretch(int unsigned items, int unsigned alloc_pct, bit allow_gaps);
        for (int unsigned n = 0; n < items; n++) begin
            if (!allow_gaps) gaps_on = 1'b0;
            else if (n % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
            send_random(alloc_pct);
        end
    endtask

    task automatic run_stimulus();
        int unsigned       h, n;
        logic [ADDR_W-1:0] pa;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings. The first requests wait out the clearing sweep.
        send(OP_READ,   32'h87FF_F000);  // never allocated: count zero, still answered
        send(OP_FREE,   32'h87FF_F000);  // free of an unallocated page
        send(OP_ADDREF, 32'h87FF_F000);  // add reference to an unallocated page
        send(OP_ALLOC,  32'h0000_0000);  // top fresh page
        send(OP_ALLOC,  32'h0000_0000);
        send(OP_ADDREF, 32'h87FF_F000);
        send(OP_READ,   32'h87FF_F000);
        send(OP_FREE,   32'h87FF_F000);
        send(OP_FREE,   32'h87FF_F000);  // count reaches zero, page goes onto the stack
        send(OP_ALLOC,  32'h0000_0000);  // served from the stack
        send(OP_FREE,   32'h87FF_E000);
        send(OP_FREE,   32'h87FF_F000);
        send(OP_ALLOC,  32'h0000_0000);  // stack is last in, first out
        send(OP_ALLOC,  32'h0000_0000);
        send(OP_ALLOC,  32'hFFFF_FFFF);  // stack empty again, address ignored
        send(OP_FREE,   32'h87FF_F001);  // misaligned
        send(OP_READ,   32'h800F_F000);  // below the first free address
        send(OP_ADDREF, 32'h8800_0000);  // at the top of memory
        send(OP_READ,   32'h0000_0000);
        send(OP_FREE,   32'hFFFF_FFFF);
        send(OP_READ,   32'h8010_0000);  // lowest page that may be handed out
        random_stretch(300, 30, 1'b1);

        // A small region with an unaligned start and end, sized to leave six fresh pages beyond
        // those already taken, so that the fresh pages run out and allocation has to live off the stack.
        wait_idle();
        write_cfg(CFG_FIRST_FREE, 32'h8010_0010);
        write_cfg(CFG_RAM_TOP, 32'h8010_1000 + (fresh_taken + 6) * PAGE_BYTES + 32'h800);
        random_stretch(200, 50, 1'b1);

        // Region from address zero, sized so that the next fresh slot is the lowest live page:
        // once the stack is emptied, that allocate must be refused and the slot consumed.
        wait_idle();
        h = NUM_PAGES;
        foreach (live_pages[k]) if (live_pages[k] < h) h = live_pages[k];
        if (h == NUM_PAGES) h = 0;
        write_cfg(CFG_RAM_BASE, 32'h0000_0000);
        write_cfg(CFG_FIRST_FREE, 32'h0000_0000);
        write_cfg(CFG_RAM_TOP, (h + fresh_taken + 1) * PAGE_BYTES);
        n = freed_depth;
        repeat (n) send(OP_ALLOC, $urandom);
        send(OP_ALLOC, 32'h0000_0000);
        send(OP_READ, h * PAGE_BYTES);
        send(OP_ALLOC, 32'h0000_0000);
        random_stretch(120, 30, 1'b1);

        // Everything rejected: base and first free at the very top, memory top at zero.
        wait_idle();
        write_cfg(CFG_RAM_BASE, 32'hFFFF_FFFF);
        write_cfg(CFG_FIRST_FREE, 32'hFFFF_FFFF);
        write_cfg(CFG_RAM_TOP, 32'h0000_0000);
        random_stretch(40, 30, 1'b1);

        // Back to the reset settings.
        wait_idle();
        write_cfg(CFG_RAM_BASE, DEFAULT_RAM_BASE);
        write_cfg(CFG_FIRST_FREE, DEFAULT_FIRST_FREE);
        write_cfg(CFG_RAM_TOP, DEFAULT_RAM_TOP);
        random_stretch(150, 30, 1'b1);

        // Saturate one count so that the later add references overflow.
        wait_idle();
        if (live_pages.size() == 0) begin
            send(OP_ALLOC, 32'h0000_0000);
            wait_idle();
        end
        pa = cfg_base + live_pages[$] * PAGE_BYTES;
        repeat (256) send(OP_ADDREF, pa);
        send(OP_READ, pa);
        send(OP_FREE, pa);

        // Final stretch back to back, without pauses.
        random_stretch(100, 30, 1'b0);

        wait_idle();
        repeat (8) @(posedge i_clk);
        mismatches += results_due.size();
    endtask

    initial begin
        fork
            run_stimulus();
            wait (stalled);
        join_any
        if (!stalled && mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/rpfa_pkg.sv
rtl/rpfa_ram.sv
rtl/rpfa_addr_unit.sv
rtl/refcounted_page_frame_allocator.sv
dv/tb_top.sv
